/* rtl/boxds_pkg.sv */
package boxds_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_CH_DEF      = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int CFG_BITS   = 13;
  localparam int IDX_BITS   = 2;
  localparam int CH_BITS    = 3;
  localparam int DIM_BITS   = 13;
  localparam int BND_BITS   = 14;
  localparam int POS_BITS   = 12;
  localparam int IN_BITS    = 16;
  localparam int OUT_BITS   = 16;
  localparam int NUM_LANES  = 4;
  localparam int NUM_BITS   = 25;
  localparam int AREA_BITS  = 25;
  localparam int EDGE_LIMIT = 4096;

  // Configuration register indexes
  typedef enum logic [IDX_BITS-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_MAX_EDGE   = 2'd2,
    CFG_CHANNELS   = 2'd3
  } cfg_idx_t;

  // Geometry setup sequencer
  typedef enum logic [2:0] {
    G_LOAD,
    G_MUL,
    G_DIV_GO,
    G_DIV_WAIT,
    G_READY
  } geom_state_t;

  // Frame geometry handed to the datapath
  typedef struct packed {
    logic                ready;
    logic                done;
    logic [DIM_BITS-1:0] eff_w;
    logic [DIM_BITS-1:0] eff_h;
    logic [CH_BITS-1:0]  eff_ch;
    logic [DIM_BITS-1:0] tw;
    logic [DIM_BITS-1:0] th;
    logic [DIM_BITS-1:0] qw;
    logic [DIM_BITS-1:0] rw;
    logic [DIM_BITS-1:0] qh;
    logic [DIM_BITS-1:0] rh;
  } geom_t;

  // Per-lane control strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic first;
    logic div_start;
  } lane_ctl_t;

endpackage

/* rtl/boxds_if.sv */
interface boxds_in_if import boxds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] sample_ch0;
  logic [IN_BITS-1:0] sample_ch1;
  logic [IN_BITS-1:0] sample_ch2;
  logic [IN_BITS-1:0] sample_ch3;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  input ready);
  modport sink (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                output ready);
endinterface

interface boxds_out_if import boxds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] mean_ch0;
  logic [OUT_BITS-1:0] mean_ch1;
  logic [OUT_BITS-1:0] mean_ch2;
  logic [OUT_BITS-1:0] mean_ch3;
  logic [POS_BITS-1:0] target_x;
  logic [POS_BITS-1:0] target_y;
  logic                frame_end;

  modport source (output valid, mean_ch0, mean_ch1, mean_ch2, mean_ch3,
                  target_x, target_y, frame_end, input ready);
  modport sink (input valid, mean_ch0, mean_ch1, mean_ch2, mean_ch3,
                target_x, target_y, frame_end, output ready);
endinterface

/* rtl/boxds_div.sv */
module boxds_div import boxds_pkg::*; #(
  parameter int N_BITS = NUM_BITS,
  parameter int D_BITS = DIM_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [N_BITS-1:0] num,
  input  logic [D_BITS-1:0] den,
  output logic              busy,
  output logic              done,
  output logic [N_BITS-1:0] quo,
  output logic [D_BITS-1:0] rem
);
  localparam int CNT_BITS = $clog2(N_BITS + 1);

  logic [N_BITS-1:0]   quo_r;
  logic [D_BITS-1:0]   rem_r;
  logic [D_BITS-1:0]   den_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [D_BITS:0]     shift;
  logic [D_BITS:0]     diff;
  logic                ge;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign shift = {rem_r, quo_r[N_BITS-1]};
  assign diff  = shift - {1'b0, den_r};
  assign ge    = (shift >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_BITS'(N_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[N_BITS-2:0], ge};
      rem_r <= ge ? diff[D_BITS-1:0] : shift[D_BITS-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

/* rtl/boxds_geom.sv */
module boxds_geom import boxds_pkg::*; #(
  parameter int WIDTH_LIMIT  = EDGE_LIMIT,
  parameter int MAX_CHANNELS = MAX_CH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CFG_BITS-1:0] src_width,
  input  logic [CFG_BITS-1:0] src_height,
  input  logic [CFG_BITS-1:0] max_edge,
  input  logic [CH_BITS-1:0]  channel_count,
  output geom_t               geom
);
  localparam logic [DIM_BITS-1:0] W_LIM  = DIM_BITS'(WIDTH_LIMIT);
  localparam logic [DIM_BITS-1:0] H_LIM  = DIM_BITS'(EDGE_LIMIT);
  localparam logic [CH_BITS-1:0]  CH_LIM = CH_BITS'(MAX_CHANNELS);

  geom_state_t         state_r, state_nxt;
  logic [1:0]          sel_r;
  logic                done_r;
  logic [DIM_BITS-1:0] eff_w_r, eff_h_r, me_r;
  logic [CH_BITS-1:0]  eff_ch_r;
  logic [NUM_BITS-1:0] num_w_r, num_h_r;
  logic [DIM_BITS-1:0] tw_r, th_r, qw_r, rw_r, qh_r, rh_r;
  logic [DIM_BITS-1:0] longest;
  logic                fits;
  logic                div_start;
  logic                div_done;
  logic                geom_ready;
  logic [NUM_BITS-1:0] div_num;
  logic [DIM_BITS-1:0] div_den;
  logic [NUM_BITS-1:0] div_quo;
  logic [DIM_BITS-1:0] div_rem;
  logic [DIM_BITS-1:0] quo_min1;

  assign longest  = (eff_w_r > eff_h_r) ? eff_w_r : eff_h_r;
  assign fits     = (longest <= me_r);
  assign quo_min1 = (div_quo == '0) ? DIM_BITS'(1) : div_quo[DIM_BITS-1:0];

  // Divider operands for each setup step
  always_comb begin
    case (sel_r)
      2'd0: begin
        div_num = num_w_r;
        div_den = longest;
      end
      2'd1: begin
        div_num = num_h_r;
        div_den = longest;
      end
      2'd2: begin
        div_num = NUM_BITS'(eff_w_r);
        div_den = tw_r;
      end
      default: begin
        div_num = NUM_BITS'(eff_h_r);
        div_den = th_r;
      end
    endcase
  end

  boxds_div #(.N_BITS(NUM_BITS), .D_BITS(DIM_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      G_LOAD:     state_nxt = G_MUL;
      G_MUL:      state_nxt = G_DIV_GO;
      G_DIV_GO:   state_nxt = G_DIV_WAIT;
      G_DIV_WAIT: if (div_done) state_nxt = (sel_r == 2'd3) ? G_READY : G_DIV_GO;
      G_READY:    state_nxt = G_READY;
      default:    state_nxt = G_LOAD;
    endcase
    if (start) state_nxt = G_LOAD;
  end

  // Outputs
  always_comb begin
    div_start  = 1'b0;
    geom_ready = 1'b0;
    case (state_r)
      G_DIV_GO: div_start  = 1'b1;
      G_READY:  geom_ready = 1'b1;
      default: begin
        div_start  = 1'b0;
        geom_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_LOAD;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == G_DIV_WAIT) && div_done && (sel_r == 2'd3) && !start;
    end
  end

  // Clamp the registers, form the products, then capture each quotient and remainder
  always_ff @(posedge clk) begin
    case (state_r)
      G_LOAD: begin
        eff_w_r  <= (src_width == '0) ? DIM_BITS'(1) :
                    ((src_width > W_LIM) ? W_LIM : src_width);
        eff_h_r  <= (src_height == '0) ? DIM_BITS'(1) :
                    ((src_height > H_LIM) ? H_LIM : src_height);
        me_r     <= (max_edge == '0) ? DIM_BITS'(1) : max_edge;
        eff_ch_r <= (channel_count == '0) ? CH_BITS'(1) :
                    ((channel_count > CH_LIM) ? CH_LIM : channel_count);
      end
      G_MUL: begin
        num_w_r <= NUM_BITS'(eff_w_r * me_r) + NUM_BITS'(longest >> 1);
        num_h_r <= NUM_BITS'(eff_h_r * me_r) + NUM_BITS'(longest >> 1);
        if (fits) begin
          tw_r  <= eff_w_r;
          th_r  <= eff_h_r;
          sel_r <= 2'd2;
        end else begin
          sel_r <= 2'd0;
        end
      end
      G_DIV_WAIT: begin
        if (div_done) begin
          case (sel_r)
            2'd0: tw_r <= quo_min1;
            2'd1: th_r <= quo_min1;
            2'd2: begin
              qw_r <= div_quo[DIM_BITS-1:0];
              rw_r <= div_rem;
            end
            default: begin
              qh_r <= div_quo[DIM_BITS-1:0];
              rh_r <= div_rem;
            end
          endcase
          sel_r <= sel_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign geom.ready  = geom_ready;
  assign geom.done   = done_r;
  assign geom.eff_w  = eff_w_r;
  assign geom.eff_h  = eff_h_r;
  assign geom.eff_ch = eff_ch_r;
  assign geom.tw     = tw_r;
  assign geom.th     = th_r;
  assign geom.qw     = qw_r;
  assign geom.rw     = rw_r;
  assign geom.qh     = qh_r;
  assign geom.rh     = rh_r;
endmodule

/* rtl/boxds_lane.sv */
module boxds_lane import boxds_pkg::*; #(
  parameter int DEPTH       = MAX_WIDTH_DEF,
  parameter int ADDR_BITS   = $clog2(MAX_WIDTH_DEF),
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = SAMPLE_BITS_DEF + 2 * POS_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lane_ctl_t              ctl,
  input  logic [ADDR_BITS-1:0]   rd_addr,
  input  logic [ADDR_BITS-1:0]   wr_addr,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [AREA_BITS-1:0]   area,
  output logic [OUT_BITS-1:0]    sum_lo,
  output logic [OUT_BITS-1:0]    quo_lo,
  output logic                   div_done
);
  logic [SUM_BITS-1:0]  mem [DEPTH];
  logic [SUM_BITS-1:0]  rdata_r;
  logic [SUM_BITS-1:0]  byp_data_r;
  logic [ADDR_BITS-1:0] byp_addr_r;
  logic                 byp_vld_r;
  logic [SUM_BITS-1:0]  base;
  logic [SUM_BITS-1:0]  sum;
  logic [SUM_BITS-1:0]  quo;
  logic [AREA_BITS-1:0] rem;

  // First pixel of a block starts a fresh sum; the last write forwards
  always_comb begin
    if (ctl.first) begin
      base = '0;
    end else if (byp_vld_r && (byp_addr_r == wr_addr)) begin
      base = byp_data_r;
    end else begin
      base = rdata_r;
    end
  end

  assign sum = base + SUM_BITS'(sample);

  // Column sum store
  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[wr_addr] <= sum;
    if (ctl.rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else if (ctl.wr_en) begin
      byp_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      byp_addr_r <= wr_addr;
      byp_data_r <= sum;
    end
  end

  boxds_div #(.N_BITS(SUM_BITS), .D_BITS(AREA_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (sum),
    .den   (area),
    .busy  (),
    .done  (div_done),
    .quo   (quo),
    .rem   (rem)
  );

  assign sum_lo = sum[OUT_BITS-1:0];
  assign quo_lo = quo[OUT_BITS-1:0];
endmodule

/* rtl/box_area_image_downscaler.sv */
// Channel | Dir | Handshake          | Transaction carries
// in_px   | in  | valid/ready        | sample_ch0..sample_ch3
// out_px  | out | valid/ready        | mean_ch0..3, target_x, target_y, frame_end
// cfg     | in  | cfg_we, no stall   | cfg_index, cfg_data (13 bits)
//
// A pixel that does not close a block, or closes a one-pixel block, needs no
// divider, so pass-through runs at one pixel per clock while the output is
// ready. A pixel closing a larger block starts the per-channel restoring
// dividers, and the next block-closing pixel waits until that result has moved
// to the output register. After reset or any register write, setup runs up to
// four divisions (two when the long edge already fits) with no pixel taken.
// Sums need no clearing pass: the first pixel of each block overwrites its
// column entry. A stalled output holds the one pending result; pixels keep
// flowing until another result.
module box_area_image_downscaler import boxds_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int MAX_CHANNELS = MAX_CH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  boxds_in_if.sink            in_px,
  boxds_out_if.source         out_px,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);
  localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
  localparam int WIDTH_LIMIT = (MAX_WIDTH < EDGE_LIMIT) ? MAX_WIDTH : EDGE_LIMIT;
  localparam int SUM_BITS    = SAMPLE_BITS + 2 * POS_BITS;

  // Configuration registers
  logic [CFG_BITS-1:0] src_width_r, src_height_r, max_edge_r;
  logic [CH_BITS-1:0]  channel_count_r;
  geom_t               geom;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r     <= CFG_BITS'(4096);
      src_height_r    <= CFG_BITS'(4096);
      max_edge_r      <= CFG_BITS'(1024);
      channel_count_r <= CH_BITS'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r     <= cfg_data;
        CFG_SRC_HEIGHT: src_height_r    <= cfg_data;
        CFG_MAX_EDGE:   max_edge_r      <= cfg_data;
        CFG_CHANNELS:   channel_count_r <= cfg_data[CH_BITS-1:0];
        default: ;
      endcase
    end
  end

  boxds_geom #(.WIDTH_LIMIT(WIDTH_LIMIT), .MAX_CHANNELS(MAX_CHANNELS)) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (cfg_we),
    .src_width     (src_width_r),
    .src_height    (src_height_r),
    .max_edge      (max_edge_r),
    .channel_count (channel_count_r),
    .geom          (geom)
  );

  // Position counters and block bounds
  logic [POS_BITS-1:0] scol_r, srow_r, scol_nxt, srow_nxt;
  logic [DIM_BITS-1:0] tcol_r, trow_r, tcol_nxt, trow_nxt;
  logic [BND_BITS-1:0] col_start_r, col_bound_r, row_start_r, row_bound_r;
  logic [BND_BITS-1:0] col_start_nxt, col_bound_nxt, row_start_nxt, row_bound_nxt;
  logic [DIM_BITS-1:0] col_acc_r, row_acc_r, col_acc_nxt, row_acc_nxt;
  logic [BND_BITS-1:0] col_acc_sum, row_acc_sum;
  logic                col_carry, row_carry;
  logic                col_last, row_last, line_end, frame_wrap;
  logic                first_px;
  logic                fe_px;
  logic [BND_BITS-1:0] col_span, row_span;

  // Stage 1 and result registers
  logic                   p1_vld_r, p1_first_r, p1_out_r, p1_fe_r;
  logic [ADDR_BITS-1:0]   p1_addr_r;
  logic [AREA_BITS-1:0]   p1_area_r;
  logic [POS_BITS-1:0]    p1_tx_r, p1_ty_r;
  logic [SAMPLE_BITS-1:0] p1_smp_r [NUM_LANES];
  logic                   dv_busy_r, dv_rdy_r, dv_fe_r;
  logic [POS_BITS-1:0]    dv_tx_r, dv_ty_r;
  logic                   out_vld_r, out_fe_r;
  logic [POS_BITS-1:0]    out_tx_r, out_ty_r;
  logic [OUT_BITS-1:0]    out_mean_r [NUM_LANES];
  logic [SAMPLE_BITS-1:0] in_smp [NUM_LANES];

  logic      geom_ok, out_free, p1_area1, p1_go, acc, div_start, ld_p1, ld_dv;
  lane_ctl_t lane_ctl;
  logic [OUT_BITS-1:0] lane_sum [NUM_LANES];
  logic [OUT_BITS-1:0] lane_quo [NUM_LANES];
  logic                lane_done [NUM_LANES];

  assign in_smp[0] = SAMPLE_BITS'(in_px.sample_ch0);
  assign in_smp[1] = SAMPLE_BITS'(in_px.sample_ch1);
  assign in_smp[2] = SAMPLE_BITS'(in_px.sample_ch2);
  assign in_smp[3] = SAMPLE_BITS'(in_px.sample_ch3);

  // Handshake control
  assign geom_ok   = geom.ready && !geom.done;
  assign out_free  = !out_vld_r || out_px.ready;
  assign p1_area1  = (p1_area_r == AREA_BITS'(1));
  assign p1_go     = p1_vld_r && (!p1_out_r || (!dv_busy_r && (!p1_area1 || out_free)));
  assign in_px.ready = geom_ok && !cfg_we && (!p1_vld_r || p1_go);
  assign acc       = in_px.valid && in_px.ready;
  assign div_start = p1_go && p1_out_r && !p1_area1;
  assign ld_p1     = p1_go && p1_out_r && p1_area1;
  assign ld_dv     = dv_rdy_r && out_free;

  assign lane_ctl.rd_en     = acc;
  assign lane_ctl.wr_en     = p1_go;
  assign lane_ctl.first     = p1_first_r;
  assign lane_ctl.div_start = div_start;

  // Block position of the incoming pixel
  assign col_last   = (BND_BITS'(scol_r) + 1'b1) >= col_bound_r;
  assign row_last   = (BND_BITS'(srow_r) + 1'b1) >= row_bound_r;
  assign line_end   = (DIM_BITS'(scol_r) + 1'b1) >= geom.eff_w;
  assign frame_wrap = (DIM_BITS'(srow_r) + 1'b1) >= geom.eff_h;
  assign first_px   = (BND_BITS'(scol_r) == col_start_r) && (BND_BITS'(srow_r) == row_start_r);
  assign fe_px      = ((tcol_r + 1'b1) >= geom.tw) && ((trow_r + 1'b1) >= geom.th);
  assign col_span   = col_bound_r - col_start_r;
  assign row_span   = row_bound_r - row_start_r;

  // Step the boundaries by quotient plus remainder carry
  assign col_acc_sum = BND_BITS'(col_acc_r) + BND_BITS'(geom.rw);
  assign row_acc_sum = BND_BITS'(row_acc_r) + BND_BITS'(geom.rh);
  assign col_carry   = col_acc_sum >= BND_BITS'(geom.tw);
  assign row_carry   = row_acc_sum >= BND_BITS'(geom.th);

  always_comb begin
    scol_nxt      = scol_r + 1'b1;
    srow_nxt      = srow_r;
    tcol_nxt      = tcol_r;
    trow_nxt      = trow_r;
    col_start_nxt = col_start_r;
    col_bound_nxt = col_bound_r;
    col_acc_nxt   = col_acc_r;
    row_start_nxt = row_start_r;
    row_bound_nxt = row_bound_r;
    row_acc_nxt   = row_acc_r;
    if (col_last) begin
      tcol_nxt      = tcol_r + 1'b1;
      col_start_nxt = col_bound_r;
      col_bound_nxt = col_bound_r + BND_BITS'(geom.qw) + BND_BITS'(col_carry);
      col_acc_nxt   = col_carry ? DIM_BITS'(col_acc_sum - BND_BITS'(geom.tw))
                                : DIM_BITS'(col_acc_sum);
    end
    if (line_end) begin
      scol_nxt      = '0;
      tcol_nxt      = '0;
      col_start_nxt = '0;
      col_bound_nxt = BND_BITS'(geom.qw);
      col_acc_nxt   = geom.rw;
      srow_nxt      = srow_r + 1'b1;
      if (row_last) begin
        trow_nxt      = trow_r + 1'b1;
        row_start_nxt = row_bound_r;
        row_bound_nxt = row_bound_r + BND_BITS'(geom.qh) + BND_BITS'(row_carry);
        row_acc_nxt   = row_carry ? DIM_BITS'(row_acc_sum - BND_BITS'(geom.th))
                                  : DIM_BITS'(row_acc_sum);
      end
      if (frame_wrap) begin
        srow_nxt      = '0;
        trow_nxt      = '0;
        row_start_nxt = '0;
        row_bound_nxt = BND_BITS'(geom.qh);
        row_acc_nxt   = geom.rh;
      end
    end
  end

  // Counters: zero on restart, first bounds once setup finishes
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      scol_r      <= '0;
      srow_r      <= '0;
      tcol_r      <= '0;
      trow_r      <= '0;
      col_start_r <= '0;
      row_start_r <= '0;
      col_bound_r <= '0;
      row_bound_r <= '0;
      col_acc_r   <= '0;
      row_acc_r   <= '0;
    end else if (geom.done) begin
      col_bound_r <= BND_BITS'(geom.qw);
      row_bound_r <= BND_BITS'(geom.qh);
      col_acc_r   <= geom.rw;
      row_acc_r   <= geom.rh;
    end else if (acc) begin
      scol_r      <= scol_nxt;
      srow_r      <= srow_nxt;
      tcol_r      <= tcol_nxt;
      trow_r      <= trow_nxt;
      col_start_r <= col_start_nxt;
      col_bound_r <= col_bound_nxt;
      col_acc_r   <= col_acc_nxt;
      row_start_r <= row_start_nxt;
      row_bound_r <= row_bound_nxt;
      row_acc_r   <= row_acc_nxt;
    end
  end

  // Stage 1 valid and divider tracking
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      p1_vld_r  <= 1'b0;
      dv_busy_r <= 1'b0;
      dv_rdy_r  <= 1'b0;
    end else begin
      if (acc) begin
        p1_vld_r <= 1'b1;
      end else if (p1_go) begin
        p1_vld_r <= 1'b0;
      end
      if (div_start) begin
        dv_busy_r <= 1'b1;
      end else if (ld_dv) begin
        dv_busy_r <= 1'b0;
      end
      if (lane_done[0] && dv_busy_r) begin
        dv_rdy_r <= 1'b1;
      end else if (ld_dv) begin
        dv_rdy_r <= 1'b0;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (acc) begin
      p1_first_r <= first_px;
      p1_out_r   <= col_last && row_last;
      p1_fe_r    <= fe_px;
      p1_addr_r  <= ADDR_BITS'(tcol_r);
      p1_area_r  <= AREA_BITS'(col_span * row_span);
      p1_tx_r    <= tcol_r[POS_BITS-1:0];
      p1_ty_r    <= trow_r[POS_BITS-1:0];
      for (int c = 0; c < NUM_LANES; c++) p1_smp_r[c] <= in_smp[c];
    end
    if (div_start) begin
      dv_tx_r <= p1_tx_r;
      dv_ty_r <= p1_ty_r;
      dv_fe_r <= p1_fe_r;
    end
  end

  // Channel lanes
  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    if (c < MAX_CHANNELS) begin : g_on
      boxds_lane #(
        .DEPTH       (MAX_WIDTH),
        .ADDR_BITS   (ADDR_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
      ) u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl),
        .rd_addr  (ADDR_BITS'(tcol_r)),
        .wr_addr  (p1_addr_r),
        .sample   (p1_smp_r[c]),
        .area     (p1_area_r),
        .sum_lo   (lane_sum[c]),
        .quo_lo   (lane_quo[c]),
        .div_done (lane_done[c])
      );
    end else begin : g_off
      assign lane_sum[c]  = '0;
      assign lane_quo[c]  = '0;
      assign lane_done[c] = 1'b0;
    end
  end

  // Merge lanes into the output register; unused channels read zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ld_p1 || ld_dv) begin
      out_vld_r <= 1'b1;
    end else if (out_px.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_p1) begin
      out_tx_r <= p1_tx_r;
      out_ty_r <= p1_ty_r;
      out_fe_r <= p1_fe_r;
    end else if (ld_dv) begin
      out_tx_r <= dv_tx_r;
      out_ty_r <= dv_ty_r;
      out_fe_r <= dv_fe_r;
    end
    for (int c = 0; c < NUM_LANES; c++) begin
      if (ld_p1 || ld_dv) begin
        if (CH_BITS'(c) < geom.eff_ch) begin
          out_mean_r[c] <= ld_p1 ? lane_sum[c] : lane_quo[c];
        end else begin
          out_mean_r[c] <= '0;
        end
      end
    end
  end

  assign out_px.valid     = out_vld_r;
  assign out_px.mean_ch0  = out_mean_r[0];
  assign out_px.mean_ch1  = out_mean_r[1];
  assign out_px.mean_ch2  = out_mean_r[2];
  assign out_px.mean_ch3  = out_mean_r[3];
  assign out_px.target_x  = out_tx_r;
  assign out_px.target_y  = out_ty_r;
  assign out_px.frame_end = out_fe_r;
endmodule
